>>> hw/rtl/adaptive_rate_audio_ring_reader_top_defines.svh
// Assertion helpers for the ring reader. They sample on clk and are off while rst is high.
`ifndef ADAPTIVE_RATE_AUDIO_RING_READER_TOP_DEFINES_SVH
`define ADAPTIVE_RATE_AUDIO_RING_READER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARAR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ARAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/arar_pkg.sv
package arar_pkg;

  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 11;
  localparam int SAMPLE_W = 16;
  localparam int PFRAME_W = 10;
  localparam int CHAN_W   = 16;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_STORE     = 2'd0;
  localparam cmd_t CMD_FRAME_END = 2'd1;
  localparam cmd_t CMD_PULL      = 2'd2;
  localparam cmd_t CMD_NOP       = 2'd3;

endpackage

>>> hw/rtl/adaptive_rate_audio_ring_reader_top.sv
// Channel  Handshake             Payload
// in       in_valid / in_ready   cmd, word_index, sample_word, producer_frame
// out      out_valid / out_ready first_channel, second_channel
//
// After reset all 2*RING_FRAMES ring words are zeroed; in_ready stays low meanwhile.
// A store inside the ring is written as it is accepted; a pull makes two reads through one shared RAM read port.
// A frame end runs the divider only at nonzero distance, DW = max(11, bits of the rate
// numerator): the rate quotient comes out of a one-bit-per-cycle restoring divider.
// Indexes outside the ring are reduced by the same divider first.
// A pull waits in its last cycle while a previous result is still held on the output.
`include "adaptive_rate_audio_ring_reader_top_defines.svh"

module adaptive_rate_audio_ring_reader_top #(
  parameter int RING_FRAMES = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [arar_pkg::CMD_W-1:0]          cmd,
  input  logic [arar_pkg::INDEX_W-1:0]        word_index,
  input  logic [arar_pkg::SAMPLE_W-1:0]       sample_word,
  input  logic [arar_pkg::PFRAME_W-1:0]       producer_frame,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [arar_pkg::CHAN_W-1:0]  first_channel,
  output logic signed [arar_pkg::CHAN_W-1:0]  second_channel
);
  import arar_pkg::*;

  localparam int HALF_WORDS = 2 * RING_FRAMES;
  localparam int AW         = $clog2(HALF_WORDS);
  localparam int FW         = $clog2(RING_FRAMES);
  localparam int PW         = FW + 8;
  localparam int RATE_NUM   = (RING_FRAMES / 2) * 256;
  localparam int RW         = $clog2(RATE_NUM + 1);
  localparam int DW         = (RW > INDEX_W) ? RW : INDEX_W;
  localparam int VW         = $clog2(HALF_WORDS + 1);
  localparam int CW         = $clog2(DW + 1);

  localparam logic [PW:0]   PHASE_SPAN  = (PW+1)'(RING_FRAMES * 256);
  localparam logic [PW-1:0] PHASE_RESET = PW'((RING_FRAMES / 2) * 256);
  localparam logic [RW-1:0] RATE_RESET  = RW'(256);
  localparam logic [FW:0]   FRAMES_EXT  = (FW+1)'(RING_FRAMES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PULL_EVEN,
    S_PULL_OUT,
    S_FE_DIST,
    S_DIV,
    S_DIV_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_STORE_MOD,
    OP_FRAME_MOD,
    OP_RATE
  } div_op_t;

  state_t               state;
  div_op_t              div_op;
  logic [AW-1:0]        clear_addr;
  logic [PW-1:0]        phase;
  logic [RW-1:0]        rate;
  logic [FW-1:0]        wr_frame;
  logic [SAMPLE_W-1:0]  sample_hold;
  logic [CHAN_W-1:0]    odd_hold;

  logic [DW-1:0]        div_dividend;
  logic [DW-1:0]        div_quot;
  logic [VW-1:0]        div_rem;
  logic [VW-1:0]        div_divisor;
  logic [CW-1:0]        div_count;

  logic                 accept;
  logic                 idx_direct;
  logic                 pf_direct;
  logic [FW-1:0]        frame;
  logic [FW:0]          dist_raw;
  logic [FW:0]          dist_wrap;
  logic [FW-1:0]        distance;
  logic [PW:0]          phase_sum;
  logic [PW-1:0]        phase_next;
  logic [VW:0]          rem_sh;
  logic [VW:0]          rem_sub;
  logic                 rem_ge;
  logic [VW-1:0]        rem_step;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [SAMPLE_W-1:0]  ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [SAMPLE_W-1:0]  ram_rdata;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign idx_direct = (word_index < HALF_WORDS);
  assign pf_direct  = (producer_frame < RING_FRAMES);
  assign frame      = phase[PW-1:8];

  // Distance from the write frame forward to the read frame, modulo the ring size.
  assign dist_raw  = {1'b0, frame} - {1'b0, wr_frame};
  assign dist_wrap = dist_raw[FW] ? (dist_raw + FRAMES_EXT) : dist_raw;
  assign distance  = dist_wrap[FW-1:0];

  // The step never exceeds half the ring, so one conditional subtract wraps the phase.
  assign phase_sum  = {1'b0, phase} + (PW+1)'(rate);
  assign phase_next = (phase_sum >= PHASE_SPAN) ? PW'(phase_sum - PHASE_SPAN)
                                                : phase_sum[PW-1:0];

  // One restoring division step: bring down the next dividend bit, subtract if it fits.
  assign rem_sh   = {div_rem, div_dividend[DW-1]};
  assign rem_ge   = (rem_sh >= {1'b0, div_divisor});
  assign rem_sub  = rem_sh - {1'b0, div_divisor};
  assign rem_step = rem_ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(word_index);
    ram_wdata = sample_word;
    priority if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clear_addr;
      ram_wdata = '0;
    end else if (state == S_DIV_DONE && div_op == OP_STORE_MOD) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(div_rem);
      ram_wdata = sample_hold;
    end else if (accept && cmd == CMD_STORE && idx_direct) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re    = (accept && cmd == CMD_PULL) || (state == S_PULL_EVEN);
  assign ram_raddr = (state == S_PULL_EVEN) ? {frame, 1'b0} : {frame, 1'b1};

  arar_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HALF_WORDS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_addr <= '0;
      out_valid  <= 1'b0;
      phase      <= PHASE_RESET;
      rate       <= RATE_RESET;
    end else begin
      // A pull in its last cycle handles the output register itself.
      if (out_valid && out_ready && state != S_PULL_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + AW'(1);
          if (clear_addr == AW'(HALF_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_STORE: begin
                sample_hold <= sample_word;
                if (!idx_direct) begin
                  div_dividend <= DW'(word_index);
                  div_divisor  <= VW'(HALF_WORDS);
                  div_rem      <= '0;
                  div_count    <= CW'(DW);
                  div_op       <= OP_STORE_MOD;
                  state        <= S_DIV;
                end
              end
              CMD_FRAME_END: begin
                if (pf_direct) begin
                  wr_frame <= FW'(producer_frame);
                  state    <= S_FE_DIST;
                end else begin
                  div_dividend <= DW'(producer_frame);
                  div_divisor  <= VW'(RING_FRAMES);
                  div_rem      <= '0;
                  div_count    <= CW'(DW);
                  div_op       <= OP_FRAME_MOD;
                  state        <= S_DIV;
                end
              end
              CMD_PULL: begin
                state <= S_PULL_EVEN;
              end
              default: begin
              end
            endcase
          end
        end
        S_PULL_EVEN: begin
          odd_hold <= ram_rdata;
          state    <= S_PULL_OUT;
        end
        S_PULL_OUT: begin
          if (!out_valid || out_ready) begin
            first_channel  <= $signed(odd_hold);
            second_channel <= $signed(ram_rdata);
            out_valid      <= 1'b1;
            phase          <= phase_next;
            state          <= S_IDLE;
          end
        end
        S_FE_DIST: begin
          // A zero distance leaves the old rate in place.
          if (distance == '0) begin
            state <= S_IDLE;
          end else begin
            div_dividend <= DW'(RATE_NUM);
            div_divisor  <= VW'(distance);
            div_rem      <= '0;
            div_count    <= CW'(DW);
            div_op       <= OP_RATE;
            state        <= S_DIV;
          end
        end
        S_DIV: begin
          div_dividend <= {div_dividend[DW-2:0], 1'b0};
          div_quot     <= {div_quot[DW-2:0], rem_ge};
          div_rem      <= rem_step;
          div_count    <= div_count - CW'(1);
          if (div_count == CW'(1)) begin
            state <= S_DIV_DONE;
          end
        end
        S_DIV_DONE: begin
          unique case (div_op)
            OP_FRAME_MOD: begin
              wr_frame <= FW'(div_rem);
              state    <= S_FE_DIST;
            end
            OP_RATE: begin
              rate  <= RW'(div_quot);
              state <= S_IDLE;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ARAR_ASSERT_IMPL(a_phase_in_ring, 1'b1, phase < PHASE_SPAN, "read phase outside the ring")
  `ARAR_ASSERT_IMPL(a_rate_nonzero, 1'b1, rate != '0, "read rate became zero")
  `ARAR_ASSERT_IMPL(a_result_from_pull, $rose(out_valid), $past(state) == S_PULL_OUT, "result without a pull")
  `ARAR_ASSERT_NEXT(a_pull_delivers, state == S_PULL_OUT && (!out_valid || out_ready), out_valid && state == S_IDLE, "pull result not presented")

endmodule

>>> hw/rtl/arar_ram.sv
module arar_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
